// File: hw/rtl/ogru_pkg.sv
// Shared constants, codes and types for the occupancy grid ray update block.
// Used by the top level and ogru_ray; depends on nothing.
package ogru_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int GCOLS_W = COL_W + 1;
  localparam int GROWS_W = ROW_W + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ERR_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 3;

  localparam int HGT_W   = 16;
  localparam int STEPS_W = 8;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 16;

  localparam logic [1:0] CELL_UNKNOWN = 2'd0;
  localparam logic [1:0] CELL_FREE    = 2'd1;
  localparam logic [1:0] CELL_OCC     = 2'd2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [CFG_A_W-1:0] REG_GRID_COLS = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_GRID_ROWS = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_START_COL = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_START_ROW = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_BAND_LOW  = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_BAND_HIGH = 3'd5;

  // control from the sequencer to the line stepper
  typedef struct packed {
    logic load;
    logic adv;
  } ray_ctl_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

endpackage

// File: hw/rtl/occupancy_grid_ray_update.sv
// Occupancy grid ray update, top level: sequencer, config registers, cell RAM.
// Insert: walks the ray from the start cell with one RAM read/write per cell visited,
// stopping at an occupied cell, then writes the endpoint; endpoint on start and read:
// one RAM read; rejected item or unused op: no RAM access; clear: RAM sweep, then the
// start cell set free if on the grid. Result shows on done_o in the cycle after the
// item finishes; no backpressure. After reset the RAM is swept to unknown with busy
// high; config writes are taken at any time. Depends on ogru_pkg, ogru_ram, ogru_ray.
module occupancy_grid_ray_update import ogru_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_A_W-1:0]  cfg_addr_i,
  input  logic [CFG_D_W-1:0]  cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op_i,
  input  logic [COL_W-1:0]    cell_col_i,
  input  logic [ROW_W-1:0]    cell_row_i,
  input  logic signed [HGT_W-1:0] height_mm_i,
  output logic                done_o,
  output logic [1:0]          cell_state_o,
  output logic                accepted_o,
  output logic [STEPS_W-1:0]  ray_steps_o,
  output logic                ray_blocked_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLR    = 3'd1;
  localparam logic [2:0] S_CLRFIN = 3'd2;
  localparam logic [2:0] S_WALK0  = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_ENDWR  = 3'd5;
  localparam logic [2:0] S_RDCELL = 3'd6;

  // config
  logic [GCOLS_W-1:0]      gcols_q;
  logic [GROWS_W-1:0]      grows_q;
  logic [COL_W-1:0]        scol_q;
  logic [ROW_W-1:0]        srow_q;
  logic signed [HGT_W-1:0] blow_q, bhigh_q;

  // sequencer
  logic [2:0]              state_q, state_d;
  logic [ADDR_W-1:0]       sweep_q, sweep_d, pend_q, pend_d;
  logic                    clr_op_q, clr_op_d;
  logic [COL_W-1:0]        ec_q, ec_d;
  logic [ROW_W-1:0]        er_q, er_d;
  logic signed [HGT_W-1:0] h_q, h_d;
  logic [STEPS_W-1:0]      steps_q, steps_d;
  logic                    blk_q, blk_d;

  // result
  logic                    done_q, done_d;
  logic [1:0]              cst_q, cst_d;
  logic                    acc_q, acc_d;
  logic [STEPS_W-1:0]      rsteps_q, rsteps_d;
  logic                    rblk_q, rblk_d;

  // RAM
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [1:0]        wdata, rdata;

  ray_ctl_t          ray_ctl;
  logic [COL_W-1:0]  cx;
  logic [ROW_W-1:0]  cy;
  logic              at_end;

  logic [GCOLS_W-1:0] cols_used;
  logic [GROWS_W-1:0] rows_used;
  logic               in_ok, st_ok, in_band, accept;
  logic [1:0]         end_new;

  always_comb begin
    cols_used = gcols_q;
    if (gcols_q == '0) cols_used = GCOLS_W'(1);
    else if (gcols_q > GCOLS_W'(MAX_COLS)) cols_used = GCOLS_W'(MAX_COLS);
    rows_used = grows_q;
    if (grows_q == '0) rows_used = GROWS_W'(1);
    else if (grows_q > GROWS_W'(MAX_ROWS)) rows_used = GROWS_W'(MAX_ROWS);
  end

  assign in_ok   = (GCOLS_W'(cell_col_i) < cols_used) && (GROWS_W'(cell_row_i) < rows_used);
  assign st_ok   = (GCOLS_W'(scol_q) < cols_used) && (GROWS_W'(srow_q) < rows_used);
  assign in_band = (h_q >= blow_q) && (h_q <= bhigh_q);
  assign end_new = (in_band || rdata == CELL_OCC) ? CELL_OCC : CELL_FREE;

  assign busy        = state_q != S_IDLE;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcols_q <= GCOLS_W'(128);
      grows_q <= GROWS_W'(64);
      scol_q  <= COL_W'(0);
      srow_q  <= ROW_W'(32);
      blow_q  <= HGT_W'(100);
      bhigh_q <= HGT_W'(1500);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_GRID_COLS: gcols_q <= cfg_data_i[GCOLS_W-1:0];
        REG_GRID_ROWS: grows_q <= cfg_data_i[GROWS_W-1:0];
        REG_START_COL: scol_q  <= cfg_data_i[COL_W-1:0];
        REG_START_ROW: srow_q  <= cfg_data_i[ROW_W-1:0];
        REG_BAND_LOW:  blow_q  <= $signed(cfg_data_i);
        REG_BAND_HIGH: bhigh_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    sweep_d  = sweep_q;
    pend_d   = pend_q;
    clr_op_d = clr_op_q;
    ec_d     = ec_q;
    er_d     = er_q;
    h_d      = h_q;
    steps_d  = steps_q;
    blk_d    = blk_q;
    done_d   = 1'b0;
    cst_d    = cst_q;
    acc_d    = acc_q;
    rsteps_d = rsteps_q;
    rblk_d   = rblk_q;
    we       = 1'b0;
    waddr    = pend_q;
    wdata    = CELL_FREE;
    re       = 1'b0;
    raddr    = cell_addr(cx, cy);
    ray_ctl  = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ec_d     = cell_col_i;
          er_d     = cell_row_i;
          h_d      = height_mm_i;
          steps_d  = '0;
          blk_d    = 1'b0;
          cst_d    = CELL_UNKNOWN;
          acc_d    = 1'b0;
          rsteps_d = '0;
          rblk_d   = 1'b0;
          case (op_i)
            OP_INSERT: begin
              if (in_ok && st_ok) begin
                if (cell_col_i == scol_q && cell_row_i == srow_q) begin
                  re      = 1'b1;
                  raddr   = cell_addr(cell_col_i, cell_row_i);
                  state_d = S_ENDWR;
                end else begin
                  ray_ctl.load = 1'b1;
                  state_d      = S_WALK0;
                end
              end else begin
                done_d = 1'b1;
              end
            end
            OP_READ: begin
              if (in_ok) begin
                re      = 1'b1;
                raddr   = cell_addr(cell_col_i, cell_row_i);
                state_d = S_RDCELL;
              end else begin
                done_d = 1'b1;
              end
            end
            OP_CLEAR: begin
              clr_op_d = 1'b1;
              sweep_d  = '0;
              state_d  = S_CLR;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        we      = 1'b1;
        waddr   = sweep_q;
        wdata   = CELL_UNKNOWN;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == ADDR_W'(DEPTH - 1)) begin
          state_d = clr_op_q ? S_CLRFIN : S_IDLE;
        end
      end
      S_CLRFIN: begin
        we      = st_ok;
        waddr   = cell_addr(scol_q, srow_q);
        wdata   = CELL_FREE;
        done_d  = 1'b1;
        cst_d   = st_ok ? CELL_FREE : CELL_UNKNOWN;
        acc_d   = st_ok;
        state_d = S_IDLE;
      end
      S_WALK0: begin
        // first ray cell is the start cell; issue its read and step on
        re          = 1'b1;
        pend_d      = cell_addr(cx, cy);
        ray_ctl.adv = 1'b1;
        state_d     = S_WALK;
      end
      S_WALK: begin
        // rdata belongs to pend_q; the next cell is read in the same cycle
        if (rdata == CELL_OCC) begin
          blk_d   = 1'b1;
          re      = 1'b1;
          raddr   = cell_addr(ec_q, er_q);
          state_d = S_ENDWR;
        end else begin
          we = 1'b1;
          if (steps_q != '1) steps_d = steps_q + 1'b1;
          if (at_end) begin
            re      = 1'b1;
            raddr   = cell_addr(ec_q, er_q);
            state_d = S_ENDWR;
          end else begin
            re          = 1'b1;
            pend_d      = cell_addr(cx, cy);
            ray_ctl.adv = 1'b1;
          end
        end
      end
      S_ENDWR: begin
        we       = 1'b1;
        waddr    = cell_addr(ec_q, er_q);
        wdata    = end_new;
        done_d   = 1'b1;
        cst_d    = end_new;
        acc_d    = 1'b1;
        rsteps_d = steps_q;
        rblk_d   = blk_q;
        state_d  = S_IDLE;
      end
      S_RDCELL: begin
        done_d  = 1'b1;
        cst_d   = rdata;
        acc_d   = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      sweep_q  <= '0;
      clr_op_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      clr_op_q <= clr_op_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    ec_q     <= ec_d;
    er_q     <= er_d;
    h_q      <= h_d;
    steps_q  <= steps_d;
    blk_q    <= blk_d;
    cst_q    <= cst_d;
    acc_q    <= acc_d;
    rsteps_q <= rsteps_d;
    rblk_q   <= rblk_d;
  end

  // endpoint comes straight from the input beat while idle, from the latch otherwise
  ogru_ray u_ray (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ray_ctl),
    .sc_i     (scol_q),
    .sr_i     (srow_q),
    .ec_i     (busy ? ec_q : cell_col_i),
    .er_i     (busy ? er_q : cell_row_i),
    .cx_o     (cx),
    .cy_o     (cy),
    .at_end_o (at_end)
  );

  ogru_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign done_o        = done_q;
  assign cell_state_o  = cst_q;
  assign accepted_o    = acc_q;
  assign ray_steps_o   = rsteps_q;
  assign ray_blocked_o = rblk_q;

endmodule

// File: hw/rtl/ogru_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ogru_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ogru_ray.sv
// Bresenham line stepper: holds the current cell and error term, one step per adv.
// Depends on ogru_pkg.
module ogru_ray import ogru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ray_ctl_t         ctl_i,
  input  logic [COL_W-1:0] sc_i,
  input  logic [ROW_W-1:0] sr_i,
  input  logic [COL_W-1:0] ec_i,
  input  logic [ROW_W-1:0] er_i,
  output logic [COL_W-1:0] cx_o,
  output logic [ROW_W-1:0] cy_o,
  output logic             at_end_o
);

  logic [COL_W-1:0]        cx_q, cx_d, dx_q, dx_d;
  logic [ROW_W-1:0]        cy_q, cy_d, dy_q, dy_d;
  logic signed [ERR_W-1:0] err_q, err_d, e2, dxs, dys;
  logic                    xneg_q, xneg_d, yneg_q, yneg_d;
  logic                    mv_x, mv_y;

  assign dxs  = $signed(ERR_W'(dx_q));
  assign dys  = $signed(ERR_W'(dy_q));
  assign e2   = err_q <<< 1;
  assign mv_x = e2 > -dys;
  assign mv_y = e2 < dxs;

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    dx_d   = dx_q;
    dy_d   = dy_q;
    err_d  = err_q;
    xneg_d = xneg_q;
    yneg_d = yneg_q;
    if (ctl_i.load) begin
      cx_d   = sc_i;
      cy_d   = sr_i;
      xneg_d = !(sc_i < ec_i);
      yneg_d = !(sr_i < er_i);
      dx_d   = (ec_i > sc_i) ? ec_i - sc_i : sc_i - ec_i;
      dy_d   = (er_i > sr_i) ? er_i - sr_i : sr_i - er_i;
      err_d  = $signed(ERR_W'(dx_d)) - $signed(ERR_W'(dy_d));
    end else if (ctl_i.adv) begin
      err_d = err_q - (mv_x ? dys : '0) + (mv_y ? dxs : '0);
      if (mv_x) begin
        cx_d = xneg_q ? cx_q - 1'b1 : cx_q + 1'b1;
      end
      if (mv_y) begin
        cy_d = yneg_q ? cy_q - 1'b1 : cy_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      dx_q   <= '0;
      dy_q   <= '0;
      err_q  <= '0;
      xneg_q <= 1'b0;
      yneg_q <= 1'b0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      err_q  <= err_d;
      xneg_q <= xneg_d;
      yneg_q <= yneg_d;
    end
  end

  assign cx_o     = cx_q;
  assign cy_o     = cy_q;
  assign at_end_o = (cx_q == ec_i) && (cy_q == er_i);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for occupancy_grid_ray_update: directed and random grid commands,
// checked against a cell map kept in the bench. Depends on ogru_pkg and the block's RTL.
module tb_top;
  import ogru_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_PRINTS  = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]              op;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic signed [HGT_W-1:0] height;
  } grid_cmd_t;

  typedef struct {
    logic [1:0]         state;
    logic               acc;
    logic [STEPS_W-1:0] steps;
    logic               blocked;
  } ray_result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_A_W-1:0]      cfg_addr_i    = REG_GRID_COLS;
  logic [CFG_D_W-1:0]      cfg_data_i    = '0;
  logic                    start         = 1'b0;
  logic                    busy;
  logic [1:0]              op_i          = OP_READ;
  logic [COL_W-1:0]        cell_col_i    = '0;
  logic [ROW_W-1:0]        cell_row_i    = '0;
  logic signed [HGT_W-1:0] height_mm_i   = '0;
  logic                    done_o;
  logic [1:0]              cell_state_o;
  logic                    accepted_o;
  logic [STEPS_W-1:0]      ray_steps_o;
  logic                    ray_blocked_o;

  occupancy_grid_ray_update DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .cell_col_i   (cell_col_i),
    .cell_row_i   (cell_row_i),
    .height_mm_i  (height_mm_i),
    .done_o       (done_o),
    .cell_state_o (cell_state_o),
    .accepted_o   (accepted_o),
    .ray_steps_o  (ray_steps_o),
    .ray_blocked_o(ray_blocked_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // bench copy of the grid and of the config registers
  logic [1:0]        cell_map [DEPTH];
  logic [7:0]        cols_reg = 8'd128;
  logic [6:0]        rows_reg = 7'd64;
  logic [6:0]        scol_reg = 7'd0;
  logic [5:0]        srow_reg = 6'd32;
  logic signed [15:0] band_lo = 16'sd100;
  logic signed [15:0] band_hi = 16'sd1500;

  grid_cmd_t   queued_cmds[$];
  ray_result_t expected_replies[$];

  bit steady;       // no random sender gaps while set; drain holds still apply
  bit drain_hold;   // sender waits for all outstanding results
  int n_mismatch, n_printed, n_results, n_cycles, n_settings;
  int n_insert, n_read, n_clear, n_unused, n_blocked, n_rejected;

  function automatic int cols_in_use();
    if (cols_reg == 0) return 1;
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int rows_in_use();
    if (rows_reg == 0) return 1;
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic bit on_grid(int c, int r);
    return c >= 0 && r >= 0 && c < cols_in_use() && r < rows_in_use();
  endfunction

  // apply one command to the bench grid and return the result it must produce
  function automatic ray_result_t update_cell_map(grid_cmd_t c);
    ray_result_t res;
    int sc, sr, ec, er, cx, cy, dx, dy, sx, sy, err, e2, guard, walked, a, h;
    bit hit;
    res = '{default: '0};
    sc = scol_reg;
    sr = srow_reg;
    ec = c.col;
    er = c.row;
    h  = c.height;
    case (c.op)
      OP_READ: begin
        if (on_grid(ec, er)) begin
          res.state = cell_map[er * MAX_COLS + ec];
          res.acc   = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (cell_map[i]) cell_map[i] = CELL_UNKNOWN;
        if (on_grid(sc, sr)) begin
          cell_map[sr * MAX_COLS + sc] = CELL_FREE;
          res.state = CELL_FREE;
          res.acc   = 1'b1;
        end
      end
      OP_INSERT: begin
        if (on_grid(ec, er) && on_grid(sc, sr)) begin
          dx = (ec > sc) ? ec - sc : sc - ec;
          dy = (er > sr) ? er - sr : sr - er;
          sx = (sc < ec) ? 1 : -1;
          sy = (sr < er) ? 1 : -1;
          err = dx - dy;
          cx = sc;
          cy = sr;
          guard = 0;
          walked = 0;
          hit = 1'b0;
          while ((cx != ec || cy != er) && guard < 2 * (MAX_COLS + MAX_ROWS) && !hit) begin
            guard++;
            a = cy * MAX_COLS + cx;
            if (cell_map[a] == CELL_OCC) begin
              hit = 1'b1;
            end else begin
              cell_map[a] = CELL_FREE;
              if (walked < 255) walked++;
              e2 = 2 * err;
              if (e2 > -dy) begin
                err -= dy;
                cx += sx;
              end
              if (e2 < dx) begin
                err += dx;
                cy += sy;
              end
            end
          end
          a = er * MAX_COLS + ec;
          if (h >= band_lo && h <= band_hi) cell_map[a] = CELL_OCC;
          else if (cell_map[a] != CELL_OCC) cell_map[a] = CELL_FREE;
          res.state   = cell_map[a];
          res.acc     = 1'b1;
          res.steps   = STEPS_W'(walked);
          res.blocked = hit;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    n_mismatch++;
    if (n_printed < MAX_PRINTS) begin
      n_printed++;
      $display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
    end
  endtask

  // driver: one command beat per start && !busy edge
  always @(posedge clk_i) begin
    grid_cmd_t   cur;
    ray_result_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        cur = queued_cmds.pop_front();
        want = update_cell_map(cur);
        expected_replies = {expected_replies, want};
        case (cur.op)
          OP_INSERT: n_insert++;
          OP_READ:   n_read++;
          OP_CLEAR:  n_clear++;
          default:   n_unused++;
        endcase
        if (cur.op == OP_INSERT && want.blocked) n_blocked++;
        if (cur.op == OP_INSERT && !want.acc) n_rejected++;
        if ($urandom_range(0, 99) < 2) drain_hold = 1'b1;
      end
      if (drain_hold && expected_replies.size() == 0) drain_hold = 1'b0;
      if (queued_cmds.size() != 0 && !drain_hold &&
          (steady || $urandom_range(0, 99) >= 30)) begin
        start       <= 1'b1;
        op_i        <= queued_cmds[0].op;
        cell_col_i  <= queued_cmds[0].col;
        cell_row_i  <= queued_cmds[0].row;
        height_mm_i <= queued_cmds[0].height;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, check each strobe
  always @(posedge clk_i) begin
    ray_result_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_replies.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, 0);
      end else begin
        want = expected_replies.pop_front();
        if (cell_state_o !== want.state) report_mismatch("cell_state", cell_state_o, want.state);
        if (accepted_o !== want.acc) report_mismatch("accepted", accepted_o, want.acc);
        if (ray_steps_o !== want.steps) report_mismatch("ray_steps", ray_steps_o, want.steps);
        if (ray_blocked_o !== want.blocked)
          report_mismatch("ray_blocked", ray_blocked_o, want.blocked);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               expected_replies.size());
      $display("[occupancy_grid_ray_update] ERROR");
      $finish;
    end
  end

  function automatic grid_cmd_t mk_cmd(logic [1:0] op, int col, int row, int h);
    grid_cmd_t c;
    c.op     = op;
    c.col    = COL_W'(col);
    c.row    = ROW_W'(row);
    c.height = HGT_W'(h);
    return c;
  endfunction

  // append one command to the driver's pending list
  task automatic add_cmd(grid_cmd_t c);
    queued_cmds = {queued_cmds, c};
  endtask

  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_GRID_COLS: cols_reg = val[7:0];
      REG_GRID_ROWS: rows_reg = val[6:0];
      REG_START_COL: scol_reg = val[6:0];
      REG_START_ROW: srow_reg = val[5:0];
      REG_BAND_LOW:  band_lo  = val;
      REG_BAND_HIGH: band_hi  = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(int cols, int rows, int scol, int srow, int lo, int hi);
    write_reg(REG_GRID_COLS, CFG_D_W'(cols));
    write_reg(REG_GRID_ROWS, CFG_D_W'(rows));
    write_reg(REG_START_COL, CFG_D_W'(scol));
    write_reg(REG_START_ROW, CFG_D_W'(srow));
    write_reg(REG_BAND_LOW, CFG_D_W'(lo));
    write_reg(REG_BAND_HIGH, CFG_D_W'(hi));
    n_settings++;
  endtask

  // wait until every queued command is taken and every result has come back
  task automatic drain();
    do @(posedge clk_i);
    while (queued_cmds.size() != 0 || expected_replies.size() != 0 || busy);
  endtask

  function automatic int pick_height();
    int lo, hi, r;
    lo = band_lo;
    hi = band_hi;
    r = $urandom_range(0, 99);
    if (r < 45 && lo <= hi) return lo + int'($urandom_range(0, hi - lo));
    if (r < 85) return int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 3))
      0:       return lo - 1;
      1:       return lo;
      2:       return hi;
      default: return hi + 1;
    endcase
  endfunction

  task automatic queue_random(int n, inout int clears_left);
    int r, col, row;
    logic [1:0] op;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 65) op = OP_INSERT;
      else if (r < 93) op = OP_READ;
      else if (r < 95) op = OP_UNUSED;
      else if (clears_left > 0 && $urandom_range(0, 9) == 0) op = OP_CLEAR;
      else op = OP_INSERT;
      if (op == OP_CLEAR) clears_left--;
      if ($urandom_range(0, 99) < 85) begin
        col = $urandom_range(0, cols_in_use() - 1);
        row = $urandom_range(0, rows_in_use() - 1);
      end else begin
        col = $urandom_range(0, MAX_COLS - 1);
        row = $urandom_range(0, MAX_ROWS - 1);
      end
      add_cmd(mk_cmd(op, col, row, pick_height()));
    end
    drain();
  endtask

  initial begin
    int clears_left;
    int cols, rows, lo;
    foreach (cell_map[i]) cell_map[i] = CELL_UNKNOWN;
    clears_left = 14;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_grid(128, 64, 0, 32, 100, 1500);

    // directed: corners, band edges, blocking, endpoint on start, clear, unused op
    add_cmd(mk_cmd(OP_READ, 0, 0, 0));
    add_cmd(mk_cmd(OP_READ, 127, 63, 0));
    add_cmd(mk_cmd(OP_INSERT, 127, 63, 1500));
    add_cmd(mk_cmd(OP_INSERT, 127, 0, 99));
    add_cmd(mk_cmd(OP_INSERT, 127, 32, 1501));
    add_cmd(mk_cmd(OP_INSERT, 64, 63, -32768));
    add_cmd(mk_cmd(OP_INSERT, 64, 0, 32767));
    add_cmd(mk_cmd(OP_READ, 127, 63, 0));
    add_cmd(mk_cmd(OP_INSERT, 10, 32, 0));
    add_cmd(mk_cmd(OP_INSERT, 20, 32, 100));
    add_cmd(mk_cmd(OP_INSERT, 40, 32, 0));     // stops at the obstacle
    add_cmd(mk_cmd(OP_INSERT, 20, 32, 0));     // occupied endpoint stays
    add_cmd(mk_cmd(OP_UNUSED, 5, 5, 200));
    add_cmd(mk_cmd(OP_READ, 30, 32, 0));
    add_cmd(mk_cmd(OP_CLEAR, 0, 0, 0));
    add_cmd(mk_cmd(OP_READ, 0, 32, 0));
    add_cmd(mk_cmd(OP_READ, 20, 32, 0));
    add_cmd(mk_cmd(OP_INSERT, 0, 32, 100));    // endpoint is the start cell
    add_cmd(mk_cmd(OP_INSERT, 5, 40, 0));      // blocked at the start cell
    add_cmd(mk_cmd(OP_INSERT, 0, 32, 0));
    add_cmd(mk_cmd(OP_CLEAR, 127, 63, -1));
    add_cmd(mk_cmd(OP_UNUSED, 127, 63, -1));
    drain();

    steady = 1'b1;
    queue_random(200, clears_left);
    steady = 1'b0;

    set_grid(128, 64, $urandom_range(0, 127), $urandom_range(0, 63), -500, 800);
    queue_random(250, clears_left);

    set_grid(16, 8, 3, 5, 0, 2000);
    queue_random(250, clears_left);

    // zero sizes clamp to a single cell
    set_grid(0, 0, 0, 0, -32768, 32767);
    queue_random(60, clears_left);

    // oversized sizes clamp to the full grid; inverted band
    set_grid(255, 127, 127, 63, 32767, -32768);
    queue_random(200, clears_left);

    // start cell off the grid
    set_grid(40, 20, 100, 50, -1000, 1000);
    add_cmd(mk_cmd(OP_CLEAR, 0, 0, 0));
    queue_random(100, clears_left);

    set_grid(1, 64, 0, 10, -32768, -32768);
    queue_random(100, clears_left);

    set_grid(128, 1, 64, 0, 32767, 32767);
    queue_random(100, clears_left);

    repeat (3) begin
      cols = $urandom_range(1, 128);
      rows = $urandom_range(1, 64);
      lo   = int'($urandom_range(0, 3000)) - 1500;
      set_grid(cols, rows, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
               lo, lo + int'($urandom_range(0, 2000)));
      queue_random(200, clears_left);
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (expected_replies.size() != 0) report_mismatch("results never returned", 0, 0);

    $display("%0d commands over %0d grid settings: %0d inserts, %0d reads, %0d clears,",
             n_insert + n_read + n_clear + n_unused, n_settings, n_insert, n_read, n_clear);
    $display("%0d unused op; %0d results checked, %0d rays blocked, %0d inserts rejected",
             n_unused, n_results, n_blocked, n_rejected);
    $display("%0d mismatches", n_mismatch);
    if (n_mismatch == 0) begin
      $display("[occupancy_grid_ray_update] OK");
    end else begin
      $display("[occupancy_grid_ray_update] ERROR");
    end
    $finish;
  end

endmodule
